FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file mcr_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/mcr_pkg.sv
// Shared constants and types of the midpoint circle rasterizer.
// No dependencies.
package mcr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;
    localparam int MAX_RADIUS    = 63;

    localparam int RADIUS_W   = 6;
    localparam int COLOR_W    = 16;
    localparam int CX_W       = 7;
    localparam int CY_W       = 8;
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = 8;
    localparam int PACK_W     = SLOTS * SLOT_W;
    // Position counters must hold values up to MAX_RADIUS (63).
    localparam int POS_W      = 7;
    // Signed coordinates: center up to 255 plus or minus the radius.
    localparam int COORD_W    = 10;
    localparam int ERR_W      = 12;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;

    localparam logic [CX_W-1:0] CENTER_X_RESET = 7'd63;
    localparam logic [CY_W-1:0] CENTER_Y_RESET = 8'd96;

    typedef struct packed {
        logic load;
        logic step;
    } mcr_cmd_t;

    typedef struct packed {
        logic last;
    } mcr_status_t;

endpackage

FILE: hw/rtl/mcr_req_if.sv
// Request channel interface of the circle rasterizer.
// Depends on mcr_pkg.
interface mcr_req_if;
    logic                         valid;
    logic                         ready;
    logic [mcr_pkg::RADIUS_W-1:0] radius;
    logic [mcr_pkg::COLOR_W-1:0]  color;

    modport source (output valid, output radius, output color, input ready);
    modport sink   (input valid, input radius, input color, output ready);
endinterface

FILE: hw/rtl/mcr_res_if.sv
// Result channel interface of the circle rasterizer.
// Depends on mcr_pkg.
interface mcr_res_if;
    logic                        valid;
    logic                        ready;
    logic [mcr_pkg::PACK_W-1:0]  x_packed;
    logic [mcr_pkg::PACK_W-1:0]  y_packed;
    logic [mcr_pkg::SLOTS-1:0]   on_screen_mask;
    logic [mcr_pkg::COLOR_W-1:0] pixel_color;
    logic                        last;

    modport source (output valid, output x_packed, output y_packed, output on_screen_mask,
                    output pixel_color, output last, input ready);
    modport sink   (input valid, input x_packed, input y_packed, input on_screen_mask,
                    input pixel_color, input last, output ready);
endinterface

FILE: hw/rtl/mcr_datapath.sv
// Datapath: center registers, midpoint loop state and the result register.
// Depends on mcr_pkg.
module mcr_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [mcr_pkg::RADIUS_W-1:0]     radius,
    input  logic [mcr_pkg::COLOR_W-1:0]      color,
    input  mcr_pkg::mcr_cmd_t                cmd,
    output mcr_pkg::mcr_status_t             status,
    output logic [mcr_pkg::PACK_W-1:0]       x_packed,
    output logic [mcr_pkg::PACK_W-1:0]       y_packed,
    output logic [mcr_pkg::SLOTS-1:0]        on_screen_mask,
    output logic [mcr_pkg::COLOR_W-1:0]      pixel_color,
    output logic                             last
);

    logic [mcr_pkg::CX_W-1:0]          center_x_reg;
    logic [mcr_pkg::CY_W-1:0]          center_y_reg;
    logic [mcr_pkg::POS_W-1:0]         x_reg, x_next;
    logic [mcr_pkg::POS_W-1:0]         y_reg, y_next;
    logic signed [mcr_pkg::ERR_W-1:0]  err_reg, err_next;
    logic [mcr_pkg::COLOR_W-1:0]       color_reg;
    logic [mcr_pkg::PACK_W-1:0]        xp_reg, xp_next;
    logic [mcr_pkg::PACK_W-1:0]        yp_reg, yp_next;
    logic [mcr_pkg::SLOTS-1:0]         mask_reg, mask_next;
    logic [mcr_pkg::COLOR_W-1:0]       pcolor_reg;
    logic                              last_reg, last_next;

    logic [mcr_pkg::POS_W-1:0]         r_sat;
    logic signed [mcr_pkg::COORD_W-1:0] cxs, cys, xs, ys;
    logic signed [mcr_pkg::COORD_W-1:0] px [mcr_pkg::SLOTS];
    logic signed [mcr_pkg::COORD_W-1:0] py [mcr_pkg::SLOTS];
    logic signed [mcr_pkg::COORD_W-1:0] lim_w, lim_h;
    logic signed [mcr_pkg::ERR_W-1:0]  xe, ye1, e1, xn_e;
    logic                              dec;

    // Center registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= mcr_pkg::CENTER_X_RESET;
            center_y_reg <= mcr_pkg::CENTER_Y_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcr_pkg::REG_CENTER_X: center_x_reg <= cfg_data[mcr_pkg::CX_W-1:0];
                mcr_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[mcr_pkg::CY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (mcr_pkg::POS_W'(radius) > mcr_pkg::POS_W'(mcr_pkg::MAX_RADIUS))
            r_sat = mcr_pkg::POS_W'(mcr_pkg::MAX_RADIUS);
        else
            r_sat = mcr_pkg::POS_W'(radius);
    end

    // Eight mirrored pixels of the current iteration.
    always_comb
    begin
        cxs   = $signed({{(mcr_pkg::COORD_W-mcr_pkg::CX_W){1'b0}}, center_x_reg});
        cys   = $signed({{(mcr_pkg::COORD_W-mcr_pkg::CY_W){1'b0}}, center_y_reg});
        xs    = $signed({{(mcr_pkg::COORD_W-mcr_pkg::POS_W){1'b0}}, x_reg});
        ys    = $signed({{(mcr_pkg::COORD_W-mcr_pkg::POS_W){1'b0}}, y_reg});
        lim_w = $signed(mcr_pkg::COORD_W'(mcr_pkg::SCREEN_WIDTH));
        lim_h = $signed(mcr_pkg::COORD_W'(mcr_pkg::SCREEN_HEIGHT));

        px[0] = cxs + xs; py[0] = cys + ys;
        px[1] = cxs + ys; py[1] = cys + xs;
        px[2] = cxs - ys; py[2] = cys + xs;
        px[3] = cxs - xs; py[3] = cys + ys;
        px[4] = cxs - xs; py[4] = cys - ys;
        px[5] = cxs - ys; py[5] = cys - xs;
        px[6] = cxs + ys; py[6] = cys - xs;
        px[7] = cxs + xs; py[7] = cys - ys;

        for (int i = 0; i < mcr_pkg::SLOTS; i++)
        begin
            xp_next[mcr_pkg::SLOT_W*i +: mcr_pkg::SLOT_W] = px[i][mcr_pkg::SLOT_W-1:0];
            yp_next[mcr_pkg::SLOT_W*i +: mcr_pkg::SLOT_W] = py[i][mcr_pkg::SLOT_W-1:0];
            mask_next[i] = (px[i] >= 0) && (px[i] < lim_w) && (py[i] >= 0) && (py[i] < lim_h);
        end
    end

    // One midpoint step. The decision 2(err - x) + 1 > 0 reduces to err >= x.
    always_comb
    begin
        xe   = $signed({{(mcr_pkg::ERR_W-mcr_pkg::POS_W){1'b0}}, x_reg});
        ye1  = $signed({{(mcr_pkg::ERR_W-mcr_pkg::POS_W){1'b0}}, y_reg})
               + mcr_pkg::ERR_W'(1);
        e1   = err_reg + ye1 + ye1 + mcr_pkg::ERR_W'(1);
        dec  = (e1 >= xe);
        xn_e = dec ? (xe - mcr_pkg::ERR_W'(1)) : xe;

        err_next  = dec ? (e1 + mcr_pkg::ERR_W'(3) - xe - xe) : e1;
        x_next    = xn_e[mcr_pkg::POS_W-1:0];
        y_next    = ye1[mcr_pkg::POS_W-1:0];
        // Signed compare: a zero radius takes x below zero.
        last_next = (xn_e < ye1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= r_sat;
            y_reg     <= '0;
            err_reg   <= '0;
            color_reg <= color;
        end
        else if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end

        if (cmd.step)
        begin
            xp_reg     <= xp_next;
            yp_reg     <= yp_next;
            mask_reg   <= mask_next;
            pcolor_reg <= color_reg;
            last_reg   <= last_next;
        end
    end

    assign status.last    = last_next;
    assign x_packed       = xp_reg;
    assign y_packed       = yp_reg;
    assign on_screen_mask = mask_reg;
    assign pixel_color    = pcolor_reg;
    assign last           = last_reg;

endmodule

FILE: hw/rtl/mcr_controller.sv
// Controller: request handshake, iteration sequencing and result valid.
// Depends on mcr_pkg.
module mcr_controller
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mcr_pkg::mcr_cmd_t     cmd,
    input  mcr_pkg::mcr_status_t  status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res_ready;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = req_valid;
                if (req_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // An iteration moves into the result register once it is free.
                if (!out_valid_reg || res_ready)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = out_valid_reg;

endmodule

FILE: hw/rtl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer. An accepted request is loaded into the loop state registers;
// results then go to the result register, one per cycle while the sink takes them, one
// iteration of the datapath's midpoint step each. A radius r gives about 0.71*r + 1 results
// (45 for r = 63); no new request is taken until the last result of one is registered.
// Reset: center goes to (63, 96), the block idles ready for a request, no result pending.
module midpoint_circle_rasterizer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    mcr_req_if.sink                         req,
    mcr_res_if.source                       res
);

    mcr_pkg::mcr_cmd_t    cmd;
    mcr_pkg::mcr_status_t status;

    mcr_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd),
        .status    (status)
    );

    mcr_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .radius         (req.radius),
        .color          (req.color),
        .cmd            (cmd),
        .status         (status),
        .x_packed       (res.x_packed),
        .y_packed       (res.y_packed),
        .on_screen_mask (res.on_screen_mask),
        .pixel_color    (res.pixel_color),
        .last           (res.last)
    );

endmodule

FILE: hw/rtl/mcr_checker.sv
// Port-level checker of the circle rasterizer, bound to the top level.
// Depends on mcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcr_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [mcr_pkg::PACK_W-1:0]  res_x_packed,
    input logic                        res_last
);

    // A held result keeps its valid and its pixels.
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)
    `ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_x_packed))

    // Once a request is taken the block is busy drawing it.
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // While idle, only the final item of a circle can still be waiting.
    `ASSERT_IMPLY(a_idle_only_last, clk, rst_n, req_ready, !(res_valid && !res_last))

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_x_packed (res.x_packed),
    .res_last     (res.last)
);
